// File: src/ilc_pkg.sv
// Shared types and constants for the IPv4 layer-4 checksum block.
`timescale 1ns / 1ps

package ilc_pkg;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [15:0] TCP_MIN_LEN = 16'd20;
  localparam logic [15:0] UDP_MIN_LEN = 16'd8;
  localparam logic [15:0] TCP_SUM_POS = 16'd16;
  localparam logic [15:0] UDP_SUM_POS = 16'd6;
  localparam logic [15:0] POS_MAX     = 16'hffff;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_PROTO = 2'd1;
  localparam logic [1:0] STATUS_TOO_SHORT = 2'd2;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [7:0]  protocol_number;
    logic [15:0] ip_total_len;
    logic [3:0]  header_words;
    logic [15:0] segment_word;
    logic        single_byte;
    logic        last_word;
  } ilc_in_t;

  typedef struct packed {
    logic [15:0] checksum_value;
    logic [1:0]  status;
  } ilc_out_t;

endpackage

// File: src/ilc_core.sv
// Per-packet accumulation state and checksum arithmetic for one segment word.
`timescale 1ns / 1ps

module ilc_core
  import ilc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     advance,
  input  logic     word_valid,
  input  ilc_in_t  word,
  output logic     result_fire,
  output ilc_out_t result
);

  logic        in_packet;
  logic [16:0] running_sum;
  logic [15:0] byte_offset;
  logic [7:0]  held_protocol;
  logic [15:0] held_segment_length;
  logic        length_error;

  logic [5:0]  ihl_bytes;
  logic        lerr_first;
  logic [15:0] seglen_first;
  logic [18:0] seed_wide;
  logic [16:0] seed_sum;
  logic [7:0]  proto_c;
  logic [15:0] seglen_c;
  logic        lerr_c;
  logic [16:0] base_sum;
  logic [15:0] pos0;
  logic [15:0] pos1;
  logic [16:0] sum1;
  logic [16:0] sum2;
  logic [15:0] offset_next;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] value;
  logic [1:0]  status;

  function automatic logic [15:0] sat_inc(input logic [15:0] p);
    return (p == POS_MAX) ? p : p + 16'd1;
  endfunction

  function automatic logic skip_pos(input logic [15:0] p, input logic [7:0] proto,
                                    input logic [15:0] len);
    logic s;
    s = (p >= len);
    if (proto == PROTO_TCP && (p == TCP_SUM_POS || p == TCP_SUM_POS + 16'd1)) s = 1'b1;
    if (proto == PROTO_UDP && (p == UDP_SUM_POS || p == UDP_SUM_POS + 16'd1)) s = 1'b1;
    return s;
  endfunction

  function automatic logic [16:0] add_byte(input logic [16:0] s, input logic [7:0] b,
                                           input logic odd);
    logic [17:0] t;
    t = {1'b0, s} + (odd ? {10'd0, b} : {2'd0, b, 8'd0});
    return {1'b0, t[15:0]} + {15'd0, t[17:16]};
  endfunction

  always_comb begin
    ihl_bytes    = {word.header_words, 2'b00};
    lerr_first   = word.ip_total_len < {10'd0, ihl_bytes};
    seglen_first = lerr_first ? 16'd0 : word.ip_total_len - {10'd0, ihl_bytes};
    seed_wide    = {3'd0, word.source_address[31:16]} + {3'd0, word.source_address[15:0]}
                 + {3'd0, word.destination_address[31:16]}
                 + {3'd0, word.destination_address[15:0]}
                 + {11'd0, word.protocol_number} + {3'd0, seglen_first};
    seed_sum     = {1'b0, seed_wide[15:0]} + {14'd0, seed_wide[18:16]};

    proto_c  = in_packet ? held_protocol       : word.protocol_number;
    seglen_c = in_packet ? held_segment_length : seglen_first;
    lerr_c   = in_packet ? length_error        : lerr_first;
    base_sum = in_packet ? running_sum         : seed_sum;
    pos0     = in_packet ? byte_offset         : 16'd0;
    pos1     = sat_inc(pos0);

    sum1 = skip_pos(pos0, proto_c, seglen_c) ? base_sum
         : add_byte(base_sum, word.segment_word[15:8], pos0[0]);
    if (word.single_byte) begin
      sum2        = sum1;
      offset_next = pos1;
    end else begin
      sum2        = skip_pos(pos1, proto_c, seglen_c) ? sum1
                  : add_byte(sum1, word.segment_word[7:0], pos1[0]);
      offset_next = sat_inc(pos1);
    end

    fold1 = {1'b0, sum2[15:0]} + {16'd0, sum2[16]};
    fold2 = fold1[15:0] + {15'd0, fold1[16]};

    if (lerr_c) begin
      status = STATUS_TOO_SHORT;
    end else if (proto_c == PROTO_TCP) begin
      status = (seglen_c < TCP_MIN_LEN) ? STATUS_TOO_SHORT : STATUS_OK;
    end else if (proto_c == PROTO_UDP) begin
      status = (seglen_c < UDP_MIN_LEN) ? STATUS_TOO_SHORT : STATUS_OK;
    end else begin
      status = STATUS_BAD_PROTO;
    end

    value = 16'd0;
    if (status == STATUS_OK) begin
      value = ~fold2;
      if (proto_c == PROTO_UDP && value == 16'd0) value = 16'hffff;
    end

    result.checksum_value = value;
    result.status         = status;
    result_fire           = word_valid && word.last_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet           <= 1'b0;
      running_sum         <= '0;
      byte_offset         <= '0;
      held_protocol       <= '0;
      held_segment_length <= '0;
      length_error        <= 1'b0;
    end else if (advance && word_valid) begin
      held_protocol       <= proto_c;
      held_segment_length <= seglen_c;
      length_error        <= lerr_c;
      if (word.last_word) begin
        in_packet   <= 1'b0;
        running_sum <= '0;
        byte_offset <= '0;
      end else begin
        in_packet   <= 1'b1;
        running_sum <= sum2;
        byte_offset <= offset_next;
      end
    end
  end

endmodule

// File: src/ilc_result_reg.sv
// Output register holding one checksum result until the receiver takes it.
`timescale 1ns / 1ps

module ilc_result_reg
  import ilc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     advance,
  input  logic     load,
  input  ilc_out_t load_data,
  output logic     sum_valid,
  output ilc_out_t sum
);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (advance) begin
      sum_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      sum <= load_data;
    end
  end

endmodule

// File: src/ipv4_l4_checksum.sv
// Top level of the TCP/UDP over IPv4 checksum block.
// Input channel seg: one transfer per 16-bit segment word, big-endian, with the
//   IPv4 header fields sampled on the first word of each packet. last_word ends
//   the packet; single_byte marks a word whose lower byte is not valid.
// Output channel sum: one transfer per packet carrying checksum_value and status.
// The result of a packet reaches sum through two registers after its last word
//   transfers (one input register, one result register).
// Throughput: one word per cycle while sum_stall does not hold the pipe; the
//   ones-complement add of the two bytes of a word into the running sum is combinational.
// Reset clears the packet state and both register valids; the next word taken
//   starts a new packet.
// When the receiver stalls a waiting result, the whole pipe holds and seg_stall
//   rises; no word or result is dropped.
`timescale 1ns / 1ps

module ipv4_l4_checksum
  import ilc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     seg_valid,
  output logic     seg_stall,
  input  ilc_in_t  seg,
  output logic     sum_valid,
  input  logic     sum_stall,
  output ilc_out_t sum
);

  logic     advance;
  logic     word_valid;
  ilc_in_t  word;
  logic     result_fire;
  ilc_out_t result;

  assign advance   = !sum_valid || !sum_stall;
  assign seg_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (advance) begin
      word_valid <= seg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && seg_valid) begin
      word <= seg;
    end
  end

  ilc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .word_valid  (word_valid),
    .word        (word),
    .result_fire (result_fire),
    .result      (result)
  );

  ilc_result_reg u_result (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .load      (result_fire),
    .load_data (result),
    .sum_valid (sum_valid),
    .sum       (sum)
  );

endmodule
